[sv/exptok_pkg.sv]
// ----------------------------------------------------------------------------
// Expression tokenizer package
// Shared constants, character codes, token kinds and queue entry types.
// ----------------------------------------------------------------------------
package exptok_pkg;

  localparam int unsigned FractionDigits = 5;
  localparam int unsigned PositionBits   = 16;

  localparam int unsigned CharW    = 8;
  localparam int unsigned KindW    = 4;
  localparam int unsigned ValueW   = 48;
  localparam int unsigned IntW     = 32;
  localparam int unsigned QuotW    = 16;
  localparam int unsigned StartW   = 16;
  localparam int unsigned LengthW  = 16;
  localparam int unsigned NameLenW = 6;

  localparam logic [NameLenW-1:0] NameLenReset = NameLenW'(20);

  // APB register map
  localparam int unsigned PaddrW = 2;
  localparam int unsigned PdataW = 32;
  localparam logic [PaddrW-1:0] AddrMaxNameLen = PaddrW'(0);

  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned r;
    r = 1;
    for (int unsigned i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  // Fraction digits are kept left-aligned as a decimal integer below FracScale
  localparam longint unsigned FracScale = pow10(FractionDigits);
  localparam int unsigned     FracW     = $clog2(FracScale);
  localparam int unsigned     FracCntW  = $clog2(FractionDigits + 1);

  // Reciprocal of FracScale for the Q.16 fraction, low by at most one
  localparam int unsigned     RecipK  = FracW + 3;
  localparam longint unsigned RecipM  = (longint'(1) << (RecipK + QuotW)) / FracScale;
  localparam int unsigned     RecipMW = $clog2(RecipM + 1);
  localparam int unsigned     ProdW   = FracW + RecipMW;
  localparam int unsigned     RemW    = FracW + QuotW + 1;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CharW-1:0] CharNul    = 8'h00;
  localparam logic [CharW-1:0] CharSpace  = 8'h20;
  localparam logic [CharW-1:0] CharLParen = 8'h28;
  localparam logic [CharW-1:0] CharRParen = 8'h29;
  localparam logic [CharW-1:0] CharStar   = 8'h2A;
  localparam logic [CharW-1:0] CharPlus   = 8'h2B;
  localparam logic [CharW-1:0] CharMinus  = 8'h2D;
  localparam logic [CharW-1:0] CharDot    = 8'h2E;
  localparam logic [CharW-1:0] CharSlash  = 8'h2F;
  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharNine   = 8'h39;
  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ = 8'h7A;

  typedef enum logic [KindW-1:0] {
    KindPlus   = 4'd0,
    KindMinus  = 4'd1,
    KindStar   = 4'd2,
    KindSlash  = 4'd3,
    KindLParen = 4'd4,
    KindRParen = 4'd5,
    KindNumber = 4'd6,
    KindName   = 4'd7,
    KindEnd    = 4'd8,
    KindError  = 4'd9
  } tok_kind_e;

  typedef enum logic [1:0] {
    ModeIdle,
    ModeInt,
    ModeFrac,
    ModeName
  } scan_mode_e;

  typedef struct packed {
    tok_kind_e           kind;
    logic [StartW-1:0]   start;
    logic [LengthW-1:0]  length;
    logic [IntW-1:0]     int_part;
    logic [FracW-1:0]    frac;
  } tok_t;

  // One character releases at most two tokens; a pending number or name comes first
  typedef struct packed {
    logic two;
    tok_t first;
    tok_t second;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  // Weight of fraction digit k: 10^(FractionDigits-1-k)
  function automatic logic [FracW-1:0] frac_weight(input logic [FracCntW-1:0] k);
    longint unsigned w;
    int unsigned     kk;
    w  = 1;
    kk = int'(k);
    for (int unsigned i = 0; i + 1 < FractionDigits; i++) begin
      if (i + kk + 1 < FractionDigits) begin
        w = w * 10;
      end
    end
    return FracW'(w);
  endfunction

endpackage

[sv/exptok_ifs.sv]
// ----------------------------------------------------------------------------
// Expression tokenizer channels
// Character input channel and token output channel, valid/ready.
// ----------------------------------------------------------------------------
interface exptok_char_if import exptok_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface exptok_token_if import exptok_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   token_kind;
  logic [ValueW-1:0]  number_value;
  logic [StartW-1:0]  token_start;
  logic [LengthW-1:0] token_length;
  logic               last_of_run;

  modport source (output valid, output token_kind, output number_value,
                  output token_start, output token_length, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input number_value,
                  input token_start, input token_length, input last_of_run,
                  output ready);
endinterface

[sv/exptok_front.sv]
// ----------------------------------------------------------------------------
// Expression tokenizer front end
// Classifies each character, tracks the token being scanned and queues the
// tokens that the character releases.
// ----------------------------------------------------------------------------
module exptok_front import exptok_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  exptok_char_if.sink         char_i,
  input  logic [NameLenW-1:0] max_name_len_i,
  input  logic                queue_full_i,
  output q_push_t             push_o
);

  scan_mode_e              mode_q, mode_d;
  logic [IntW-1:0]         int_q, int_d;
  logic [FracW-1:0]        frac_q, frac_d;
  logic [FracCntW-1:0]     fcnt_q, fcnt_d;
  logic [PositionBits-1:0] start_q, start_d;
  logic [PositionBits-1:0] pos_q, pos_d;
  logic [NameLenW-1:0]     letters_q, letters_d;
  logic [LengthW-1:0]      run_q, run_d;

  logic                accept;
  logic [CharW-1:0]    c;
  logic                is_digit, is_letter, is_op;
  logic [3:0]          digit_val;
  tok_kind_e           op_kind;
  logic [NameLenW-1:0] limit;
  logic                cont, emit_pend, name_split;
  logic [IntW+3:0]     int_mac;
  logic [IntW-1:0]     int_sat;
  logic [FracW+3:0]    frac_mul;
  logic [LengthW-1:0]  run_grow;
  tok_t                pend_tok, new_tok;
  logic                new_v;

  assign char_i.ready = !queue_full_i;
  assign accept       = char_i.valid && char_i.ready;
  assign c            = char_i.char_code;

  assign is_digit  = (c >= CharZero) && (c <= CharNine);
  assign is_letter = ((c >= CharLowerA) && (c <= CharLowerZ)) ||
                     ((c >= CharUpperA) && (c <= CharUpperZ));
  assign digit_val = c[3:0];
  assign limit     = (max_name_len_i == '0) ? NameLenW'(1) : max_name_len_i;

  always_comb begin
    is_op   = 1'b1;
    op_kind = KindError;
    case (c)
      CharPlus:   op_kind = KindPlus;
      CharMinus:  op_kind = KindMinus;
      CharStar:   op_kind = KindStar;
      CharSlash:  op_kind = KindSlash;
      CharLParen: op_kind = KindLParen;
      CharRParen: op_kind = KindRParen;
      default:    is_op = 1'b0;
    endcase
  end

  // Saturating decimal shift-in of the integer part
  assign int_mac  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + (IntW + 4)'(digit_val);
  assign int_sat  = (|int_mac[IntW+3:IntW]) ? '1 : int_mac[IntW-1:0];
  assign frac_mul = (FracW + 4)'(digit_val) * (FracW + 4)'(frac_weight(fcnt_q));
  assign run_grow = (run_q == '1) ? run_q : run_q + 1'b1;

  // Does the character extend the pending token, and is that token released?
  always_comb begin
    cont       = 1'b0;
    emit_pend  = 1'b0;
    name_split = 1'b0;
    unique case (mode_q)
      ModeIdle: begin
        cont = 1'b0;
      end
      ModeInt: begin
        cont      = is_digit || (c == CharDot);
        emit_pend = !cont;
      end
      ModeFrac: begin
        cont      = is_digit;
        emit_pend = !cont;
      end
      ModeName: begin
        cont       = is_letter;
        name_split = is_letter && (letters_q >= limit);
        emit_pend  = !is_letter || name_split;
      end
      default: begin
        cont = 1'b0;
      end
    endcase
  end

  // Next scan mode
  always_comb begin
    mode_d = mode_q;
    if (accept) begin
      unique case (mode_q)
        ModeInt: begin
          if (c == CharDot) begin
            mode_d = ModeFrac;
          end else if (!is_digit) begin
            mode_d = ModeIdle;
          end
        end
        ModeFrac: begin
          if (!is_digit) mode_d = ModeIdle;
        end
        ModeName: begin
          if (!is_letter) mode_d = ModeIdle;
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
      if (!cont) begin
        if (is_digit) begin
          mode_d = ModeInt;
        end else if (is_letter) begin
          mode_d = ModeName;
        end
      end
    end
  end

  // Accumulators, position and released tokens
  always_comb begin
    int_d     = int_q;
    frac_d    = frac_q;
    fcnt_d    = fcnt_q;
    start_d   = start_q;
    letters_d = letters_q;
    run_d     = run_q;
    pos_d     = pos_q;
    new_v     = 1'b0;
    new_tok   = '{kind: KindError, start: StartW'(pos_q), length: LengthW'(1),
                  int_part: '0, frac: '0};
    if (accept) begin
      pos_d = pos_q + 1'b1;
      if (cont) begin
        unique case (mode_q)
          ModeInt: begin
            if (is_digit) int_d = int_sat;
            run_d = run_grow;
          end
          ModeFrac: begin
            // digits past the kept depth still count towards the length
            if (fcnt_q < FracCntW'(FractionDigits)) begin
              frac_d = frac_q + frac_mul[FracW-1:0];
              fcnt_d = fcnt_q + 1'b1;
            end
            run_d = run_grow;
          end
          ModeName: begin
            if (name_split) begin
              start_d   = pos_q;
              letters_d = NameLenW'(1);
            end else begin
              letters_d = letters_q + 1'b1;
            end
          end
          default: begin
            pos_d = pos_q + 1'b1;
          end
        endcase
      end else if (c == CharNul) begin
        new_v          = 1'b1;
        new_tok.kind   = KindEnd;
        new_tok.length = '0;
        pos_d          = '0;
      end else if (is_op) begin
        new_v        = 1'b1;
        new_tok.kind = op_kind;
      end else if (is_digit) begin
        int_d   = IntW'(digit_val);
        frac_d  = '0;
        fcnt_d  = '0;
        start_d = pos_q;
        run_d   = LengthW'(1);
      end else if (is_letter) begin
        start_d   = pos_q;
        letters_d = NameLenW'(1);
      end else if (c != CharSpace) begin
        new_v = 1'b1;
      end
    end
  end

  always_comb begin
    pend_tok.kind     = (mode_q == ModeName) ? KindName : KindNumber;
    pend_tok.start    = StartW'(start_q);
    pend_tok.length   = (mode_q == ModeName) ? LengthW'(letters_q) : run_q;
    pend_tok.int_part = int_q;
    pend_tok.frac     = frac_q;
  end

  assign push_o.valid        = accept && (emit_pend || new_v);
  assign push_o.entry.two    = emit_pend && new_v;
  assign push_o.entry.first  = emit_pend ? pend_tok : new_tok;
  assign push_o.entry.second = new_tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeIdle;
      int_q     <= '0;
      frac_q    <= '0;
      fcnt_q    <= '0;
      start_q   <= '0;
      pos_q     <= '0;
      letters_q <= '0;
      run_q     <= '0;
    end else begin
      mode_q    <= mode_d;
      int_q     <= int_d;
      frac_q    <= frac_d;
      fcnt_q    <= fcnt_d;
      start_q   <= start_d;
      pos_q     <= pos_d;
      letters_q <= letters_d;
      run_q     <= run_d;
    end
  end

endmodule

[sv/exptok_queue.sv]
// ----------------------------------------------------------------------------
// Expression tokenizer token queue
// Short register FIFO of token entries between the front and back ends.
// ----------------------------------------------------------------------------
module exptok_queue import exptok_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_push_t  push_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     avail_o,
  output q_entry_t head_o
);

  q_entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_q, rd_q;
  logic [QueueCntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_q] <= push_i.entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= (wr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i.valid && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i.valid && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[sv/exptok_back.sv]
// ----------------------------------------------------------------------------
// Expression tokenizer back end
// Takes queue entries, converts the decimal fraction to Q.16 and drives the
// token channel one beat at a time through an output register.
// ----------------------------------------------------------------------------
module exptok_back import exptok_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  q_entry_t       head_i,
  output logic           pop_o,
  exptok_token_if.source token_o
);

  logic               s1_valid_q, s1_idx_q;
  q_entry_t           s1_q;
  logic [ProdW-1:0]   prod_q;

  logic               out_valid_q;
  tok_kind_e          kind_q;
  logic [ValueW-1:0]  value_q;
  logic [StartW-1:0]  start_q;
  logic [LengthW-1:0] len_q;
  logic               last_q;

  logic               out_load, s1_fire, s1_done;
  tok_t               sel;
  logic [QuotW-1:0]   q_est, quot;
  logic [RemW-1:0]    rem;
  logic [ValueW-1:0]  value_d;

  assign out_load = !out_valid_q || token_o.ready;
  assign s1_fire  = s1_valid_q && out_load;
  assign s1_done  = s1_fire && (!s1_q.two || s1_idx_q);
  assign pop_o    = avail_i && (!s1_valid_q || s1_done);

  assign sel = s1_idx_q ? s1_q.second : s1_q.first;

  // Reciprocal estimate is low by at most one: correct with one compare
  assign q_est = prod_q[RecipK +: QuotW];
  assign rem   = {1'b0, s1_q.first.frac, QuotW'(0)} - RemW'(q_est) * RemW'(FracScale);
  assign quot  = (rem >= RemW'(FracScale)) ? q_est + 1'b1 : q_est;

  assign value_d = (sel.kind == KindNumber) ? {sel.int_part, quot} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_idx_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
        s1_idx_q   <= 1'b0;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end else if (s1_fire) begin
        s1_idx_q <= 1'b1;
      end
      if (out_load) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q   <= head_i;
      prod_q <= ProdW'(head_i.first.frac) * ProdW'(RecipM);
    end
    if (s1_fire) begin
      kind_q  <= sel.kind;
      value_q <= value_d;
      start_q <= sel.start;
      len_q   <= sel.length;
      last_q  <= s1_idx_q || !s1_q.two;
    end
  end

  assign token_o.valid        = out_valid_q;
  assign token_o.token_kind   = kind_q;
  assign token_o.number_value = value_q;
  assign token_o.token_start  = start_q;
  assign token_o.token_length = len_q;
  assign token_o.last_of_run  = last_q;

endmodule

[sv/expression_tokenizer.sv]
// ----------------------------------------------------------------------------
// Expression tokenizer
// Streaming lexer for arithmetic expressions, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   char_i carries one character per beat; code 0 ends the expression and
//   yields the end token. token_o carries one token per beat, last_of_run
//   marking the final token released by a character. max_name_len sits at
//   APB address 0; the user writes it only while the block is idle (not enforced).
// Timing:
//   A character is taken every cycle while the queue is not full. A number or
//   name token is released by the character that follows it; its beat then
//   passes the queue write, the fraction multiply and the output register.
//   A character releasing two tokens holds the back end until both are loaded;
//   the four-entry token queue absorbs these; unstalled, input keeps one per cycle.
// Reset:
//   Scanner idle, position 0, queue empty, max_name_len 20.
// Stall:
//   While token_o is stalled the output register holds its beat; the queue
//   fills and char_i.ready drops once it is full.
// ----------------------------------------------------------------------------
module expression_tokenizer import exptok_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  exptok_char_if.sink       char_i,
  exptok_token_if.source    token_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [NameLenW-1:0] max_name_len_q;
  q_push_t             push;
  logic                full, avail, pop;
  q_entry_t            head;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrMaxNameLen) ? PdataW'(max_name_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_name_len_q <= NameLenReset;
    end else if (psel && penable && pwrite && pready && (paddr == AddrMaxNameLen)) begin
      max_name_len_q <= pwdata[NameLenW-1:0];
    end
  end

  exptok_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_i         (char_i),
    .max_name_len_i (max_name_len_q),
    .queue_full_i   (full),
    .push_o         (push)
  );

  exptok_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .head_o  (head)
  );

  exptok_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .head_i  (head),
    .pop_o   (pop),
    .token_o (token_o)
  );

endmodule
